>>> src/itep_pkg.sv
// Shared types and constants for the interrupt table entry parser.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package itep_pkg;

   // default caps on the number of records kept
   localparam int MAX_PROCESSORS_DEFAULT = 64;
   localparam int MAX_IO_UNITS_DEFAULT   = 16;

   // table layout
   localparam int          ENTRY_BUF      = 12;
   localparam logic [31:0] ENTRY_FIRST    = 32'd44;
   localparam logic [31:0] HDR_LEN_OFF    = 32'd4;
   localparam logic [31:0] HDR_LOCAL_OFF  = 32'd36;
   localparam logic [63:0] LOCAL_DEFAULT  = 64'h0000_0000_FEE0_0000;
   localparam logic [7:0]  ENABLED_BIT    = 8'h01;
   localparam logic [31:0] OFFSET_MAX     = 32'hFFFF_FFFF;

   // entry type codes
   localparam logic [7:0] ENTRY_CPU      = 8'd0;
   localparam logic [7:0] ENTRY_IO       = 8'd1;
   localparam logic [7:0] ENTRY_OVERRIDE = 8'd5;

   // field widths of the result channel
   localparam int CPU_TOTAL_W = 7;
   localparam int IO_TOTAL_W  = 5;

   typedef enum logic [1:0] {
      KIND_CPU     = 2'd0,
      KIND_IO      = 2'd1,
      KIND_SUMMARY = 2'd2
   } record_kind_type;

   typedef struct packed {
      record_kind_type         record_kind;
      logic [7:0]              processor_uid;
      logic [7:0]              unit_id;
      logic [31:0]             io_base_addr;
      logic [31:0]             irq_base;
      logic [63:0]             local_base_addr;
      logic [CPU_TOTAL_W-1:0]  cpu_total;
      logic [IO_TOTAL_W-1:0]   io_total;
      logic                    success;
      logic                    run_end;
   } result_type;

endpackage

>>> src/itep_if.sv
// Stream channel interfaces for the interrupt table entry parser.
// Depends on itep_pkg for the record kind type and the count field widths.
`timescale 1ns / 1ps

interface itep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface itep_rsp_if;
   logic                             valid;
   logic                             ready;
   itep_pkg::record_kind_type        record_kind;
   logic [7:0]                       processor_uid;
   logic [7:0]                       unit_id;
   logic [31:0]                      io_base_addr;
   logic [31:0]                      irq_base;
   logic [63:0]                      local_base_addr;
   logic [itep_pkg::CPU_TOTAL_W-1:0] cpu_total;
   logic [itep_pkg::IO_TOTAL_W-1:0]  io_total;
   logic                             success;
   logic                             run_end;

   modport source (output valid, output record_kind, output processor_uid,
                   output unit_id, output io_base_addr, output irq_base,
                   output local_base_addr, output cpu_total, output io_total,
                   output success, output run_end, input ready);
   modport sink   (input valid, input record_kind, input processor_uid,
                   input unit_id, input io_base_addr, input irq_base,
                   input local_base_addr, input cpu_total, input io_total,
                   input success, input run_end, output ready);
endinterface

>>> src/interrupt_table_entry_parser_top.sv
// Top level of the interrupt table entry parser: byte parser and result queue.
// Depends on itep_pkg and the channel interfaces in itep_if.sv.
`timescale 1ns / 1ps

// Takes one table byte per cycle on the request channel, header first. Each
// accepted byte is parsed in the cycle it is transferred: header fields are
// captured, the type-length entry under the current offset is collected, and
// any record it completes, plus the summary on a final byte, is written into
// a three-deep result queue. A result is registered in the queue as its byte
// is transferred. A byte makes zero, one or two results. Request ready is high
// while at most one result is queued, so with the result side taking one
// result per cycle the block takes one byte per cycle, except that a byte
// that makes two results (a final byte that completes a record) holds request
// ready low until the queue is back to one result; a slower result side
// throttles requests through the queue fill. A final byte returns all parse
// state to its reset values, so the next byte starts a new table.
// There is no clearing pass after reset.
module interrupt_table_entry_parser_top #(
   parameter int MAX_PROCESSORS = itep_pkg::MAX_PROCESSORS_DEFAULT,
   parameter int MAX_IO_UNITS   = itep_pkg::MAX_IO_UNITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   itep_req_if.sink  req_chan,
   itep_rsp_if.source rsp_chan
);

   localparam int PCNT_W  = $clog2(MAX_PROCESSORS + 1);
   localparam int IOCNT_W = $clog2(MAX_IO_UNITS + 1);
   localparam int QDEPTH  = 3;

   // parse state
   logic [31:0]       byte_offset_ff, byte_offset_in;
   logic [31:0]       table_length_ff, table_length_in;
   logic [63:0]       local_address_ff, local_address_in;
   logic [31:0]       entry_start_ff, entry_start_in;
   logic [7:0]        entry_ff [itep_pkg::ENTRY_BUF];
   logic [7:0]        entry_in [itep_pkg::ENTRY_BUF];
   logic [PCNT_W-1:0] pcount_ff, pcount_in;
   logic [IOCNT_W-1:0] iocount_ff, iocount_in;
   logic              halted_ff, halted_in;

   // result queue
   itep_pkg::result_type queue_ff [QDEPTH];
   itep_pkg::result_type queue_in [QDEPTH];
   logic [1:0]        qcount_ff, qcount_in;

   // per-byte results
   logic              req_xfer;
   logic              rsp_xfer;
   logic              rec_push;
   logic              sum_push;
   itep_pkg::result_type rec_res;
   itep_pkg::result_type sum_res;

   assign req_chan.ready = (qcount_ff <= 2'd1);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;

   // byte parse: header capture, entry collection, record and summary build
   always_comb begin
      logic [31:0] off;
      logic [7:0]  b;
      logic [1:0]  lane;
      logic        active;
      logic [31:0] idx;
      logic [7:0]  len;
      logic [7:0]  buf_w [itep_pkg::ENTRY_BUF];
      logic [31:0] addr_lo;
      logic [31:0] addr_hi;
      logic        finish;

      off  = byte_offset_ff;
      b    = req_chan.data_byte;
      lane = off[1:0];

      table_length_in  = table_length_ff;
      local_address_in = local_address_ff;
      entry_start_in   = entry_start_ff;
      pcount_in        = pcount_ff;
      iocount_in       = iocount_ff;
      halted_in        = halted_ff;
      rec_push         = 1'b0;
      rec_res          = '0;
      finish           = 1'b0;

      // header fields
      if ((off >> 2) == (itep_pkg::HDR_LEN_OFF >> 2)) begin
         table_length_in[8*lane +: 8] = b;
      end
      if (off == itep_pkg::HDR_LOCAL_OFF) begin
         local_address_in = {56'd0, b};
      end else if ((off >> 2) == (itep_pkg::HDR_LOCAL_OFF >> 2)) begin
         local_address_in[8*lane +: 8] = b;
      end

      // entry collection
      active = !halted_ff && (off >= entry_start_ff) && (entry_start_ff < table_length_in);
      idx    = off - entry_start_ff;
      for (int i = 0; i < itep_pkg::ENTRY_BUF; i++) begin
         buf_w[i] = (idx == 32'd0) ? 8'd0 : entry_ff[i];
         if (idx == 32'(i)) begin
            buf_w[i] = b;
         end
      end
      len     = buf_w[1];
      addr_lo = {buf_w[7], buf_w[6], buf_w[5], buf_w[4]};
      addr_hi = {buf_w[11], buf_w[10], buf_w[9], buf_w[8]};

      if (active && (idx != 32'd0)) begin
         if (len == 8'd0) begin
            halted_in = 1'b1;
         end else if (({1'b0, idx} + 33'd1) >= {25'd0, len}) begin
            if (({1'b0, entry_start_ff} + {25'd0, len}) > {1'b0, table_length_in}) begin
               halted_in = 1'b1;
            end else begin
               finish         = 1'b1;
               entry_start_in = entry_start_ff + {24'd0, len};
            end
         end
      end

      // completed entry
      if (finish) begin
         case (buf_w[0])
            itep_pkg::ENTRY_CPU: begin
               if (((buf_w[4] & itep_pkg::ENABLED_BIT) != 8'd0) &&
                   (pcount_ff < PCNT_W'(MAX_PROCESSORS))) begin
                  pcount_in             = pcount_ff + PCNT_W'(1);
                  rec_push              = 1'b1;
                  rec_res.record_kind   = itep_pkg::KIND_CPU;
                  rec_res.processor_uid = buf_w[2];
                  rec_res.unit_id       = buf_w[3];
               end
            end
            itep_pkg::ENTRY_IO: begin
               if (iocount_ff < IOCNT_W'(MAX_IO_UNITS)) begin
                  iocount_in           = iocount_ff + IOCNT_W'(1);
                  rec_push             = 1'b1;
                  rec_res.record_kind  = itep_pkg::KIND_IO;
                  rec_res.unit_id      = buf_w[2];
                  rec_res.io_base_addr = addr_lo;
                  rec_res.irq_base     = addr_hi;
               end
            end
            itep_pkg::ENTRY_OVERRIDE: begin
               local_address_in = {addr_hi, addr_lo};
            end
            default: begin
            end
         endcase
      end

      // entry buffer next value; a length-one entry hands this byte on as a type
      for (int i = 0; i < itep_pkg::ENTRY_BUF; i++) begin
         entry_in[i] = buf_w[i];
      end
      if (finish && ({24'd0, len} <= idx)) begin
         for (int i = 0; i < itep_pkg::ENTRY_BUF; i++) begin
            entry_in[i] = 8'd0;
         end
         entry_in[0] = b;
      end

      byte_offset_in = (off == itep_pkg::OFFSET_MAX) ? off : off + 32'd1;

      // summary
      sum_push                = req_chan.final_byte;
      sum_res                 = '0;
      sum_res.record_kind     = itep_pkg::KIND_SUMMARY;
      sum_res.local_base_addr = local_address_in;
      sum_res.cpu_total       = itep_pkg::CPU_TOTAL_W'(pcount_in);
      sum_res.io_total        = itep_pkg::IO_TOTAL_W'(iocount_in);
      sum_res.success         = (pcount_in != '0);
      sum_res.run_end         = 1'b1;
      rec_res.run_end         = !req_chan.final_byte;

      // a final byte starts the next table from reset values
      if (req_chan.final_byte) begin
         byte_offset_in   = 32'd0;
         table_length_in  = 32'd0;
         local_address_in = itep_pkg::LOCAL_DEFAULT;
         entry_start_in   = itep_pkg::ENTRY_FIRST;
         pcount_in        = '0;
         iocount_in       = '0;
         halted_in        = 1'b0;
         for (int i = 0; i < itep_pkg::ENTRY_BUF; i++) begin
            entry_in[i] = 8'd0;
         end
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff   <= 32'd0;
         table_length_ff  <= 32'd0;
         local_address_ff <= itep_pkg::LOCAL_DEFAULT;
         entry_start_ff   <= itep_pkg::ENTRY_FIRST;
         pcount_ff        <= '0;
         iocount_ff       <= '0;
         halted_ff        <= 1'b0;
         for (int i = 0; i < itep_pkg::ENTRY_BUF; i++) begin
            entry_ff[i] <= 8'd0;
         end
      end else if (req_xfer) begin
         byte_offset_ff   <= byte_offset_in;
         table_length_ff  <= table_length_in;
         local_address_ff <= local_address_in;
         entry_start_ff   <= entry_start_in;
         pcount_ff        <= pcount_in;
         iocount_ff       <= iocount_in;
         halted_ff        <= halted_in;
         for (int i = 0; i < itep_pkg::ENTRY_BUF; i++) begin
            entry_ff[i] <= entry_in[i];
         end
      end
   end

   // result queue: pop from the head, append record then summary
   always_comb begin
      logic [1:0] base;
      logic       push_a;
      logic       push_b;
      itep_pkg::result_type item_a;

      base   = qcount_ff - {1'b0, rsp_xfer};
      push_a = req_xfer && (rec_push || sum_push);
      push_b = req_xfer && rec_push && sum_push;
      item_a = rec_push ? rec_res : sum_res;

      for (int i = 0; i < QDEPTH; i++) begin
         if (rsp_xfer && (i < QDEPTH - 1)) begin
            queue_in[i] = queue_ff[(i < QDEPTH - 1) ? i + 1 : i];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if (push_a && (base == 2'(i))) begin
            queue_in[i] = item_a;
         end
         if (push_b && ((base + 2'd1) == 2'(i))) begin
            queue_in[i] = sum_res;
         end
      end
      qcount_in = base + {1'b0, push_a} + {1'b0, push_b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcount_ff <= 2'd0;
      end else begin
         qcount_ff <= qcount_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   // result channel driven from the queue head
   assign rsp_chan.valid           = (qcount_ff != 2'd0);
   assign rsp_chan.record_kind     = queue_ff[0].record_kind;
   assign rsp_chan.processor_uid   = queue_ff[0].processor_uid;
   assign rsp_chan.unit_id         = queue_ff[0].unit_id;
   assign rsp_chan.io_base_addr    = queue_ff[0].io_base_addr;
   assign rsp_chan.irq_base        = queue_ff[0].irq_base;
   assign rsp_chan.local_base_addr = queue_ff[0].local_base_addr;
   assign rsp_chan.cpu_total       = queue_ff[0].cpu_total;
   assign rsp_chan.io_total        = queue_ff[0].io_total;
   assign rsp_chan.success         = queue_ff[0].success;
   assign rsp_chan.run_end         = queue_ff[0].run_end;

`ifndef SYNTHESIS
   // a halted parse produces no records
   a_halted_no_record: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !rec_push)
      else $error("record built while parsing is halted");

   // a summary always closes the results of its byte
   a_summary_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && (rsp_chan.record_kind == itep_pkg::KIND_SUMMARY)) |-> rsp_chan.run_end)
      else $error("summary without run_end");

   // a final byte restarts the offset for the next table
   a_final_restart: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_chan.final_byte) |=> (byte_offset_ff == 32'd0))
      else $error("offset not restarted after final byte");

   // entries never start inside the header
   a_entry_start_floor: assert property (@(posedge clock) disable iff (reset)
      entry_start_ff >= itep_pkg::ENTRY_FIRST)
      else $error("entry start below first entry offset");

   // the queue never overflows its three slots
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (qcount_ff <= 2'd1) || !req_xfer)
      else $error("request transfer with queue too full");
`endif

endmodule
